// ===== rtl/pss_pkg.sv =====
// Shared constants, types and codes for the physics substep scheduler.
`default_nettype none

package pss_pkg;

  localparam int TIME_WIDTH      = 24;
  localparam int COUNT_WIDTH     = 8;
  localparam int CAP_WIDTH       = 8;
  localparam int ACC_WIDTH       = TIME_WIDTH + 1;
  localparam int PROD_WIDTH      = CAP_WIDTH + TIME_WIDTH;
  localparam int DIV_CNT_WIDTH   = $clog2(ACC_WIDTH + 1);
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = (TIME_WIDTH > CAP_WIDTH) ? TIME_WIDTH : CAP_WIDTH;
  localparam int IN_TDATA_WIDTH  = ((TIME_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_WIDTH = ((COUNT_WIDTH + TIME_WIDTH + 7) / 8) * 8;

  localparam logic [TIME_WIDTH-1:0] STEP_RESET = TIME_WIDTH'(1092);
  localparam logic [CAP_WIDTH-1:0]  CAP_RESET  = CAP_WIDTH'(8);
  localparam logic [ACC_WIDTH-1:0]  ACC_MAX    = '1;

  localparam logic MODE_FIXED    = 1'b0;
  localparam logic MODE_VARIABLE = 1'b1;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODE         = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FIXED_STEP   = CFG_INDEX_WIDTH'(1);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_STEP     = CFG_INDEX_WIDTH'(2);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_STEP     = CFG_INDEX_WIDTH'(3);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_SUBSTEPS = CFG_INDEX_WIDTH'(4);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_CHECK,
    ST_DIV1,
    ST_COUNT,
    ST_BRANCH,
    ST_DIV2,
    ST_LENGTH,
    ST_MULT,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic accum;
    logic no_step;
    logic div_start;
    logic div_sel;
    logic take_count;
    logic take_length;
    logic mult;
    logic update;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic reach;
    logic div_done;
    logic count_zero;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/pss_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module pss_div (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  start,
  input  wire  [pss_pkg::ACC_WIDTH-1:0]        num,
  input  wire  [pss_pkg::TIME_WIDTH-1:0]       den,
  output logic [pss_pkg::ACC_WIDTH-1:0]        quot,
  output logic [pss_pkg::TIME_WIDTH-1:0]       rem,
  output logic                                 done
);

  logic [pss_pkg::ACC_WIDTH-1:0]     rq;
  logic [pss_pkg::TIME_WIDTH-1:0]    r;
  logic [pss_pkg::TIME_WIDTH-1:0]    dreg;
  logic [pss_pkg::DIV_CNT_WIDTH-1:0] cnt;
  logic [pss_pkg::TIME_WIDTH:0]      trial;
  logic                              ge;
  logic [pss_pkg::TIME_WIDTH-1:0]    r_next;
  logic [pss_pkg::ACC_WIDTH-1:0]     rq_next;

  // A zero divisor always passes the trial, which yields an all-ones quotient.
  always_comb begin
    trial   = {r, rq[pss_pkg::ACC_WIDTH-1]};
    ge      = trial >= {1'b0, dreg};
    r_next  = ge ? pss_pkg::TIME_WIDTH'(trial - {1'b0, dreg})
                 : trial[pss_pkg::TIME_WIDTH-1:0];
    rq_next = {rq[pss_pkg::ACC_WIDTH-2:0], ge};
  end

  assign quot = rq;
  assign rem  = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= pss_pkg::DIV_CNT_WIDTH'(pss_pkg::ACC_WIDTH);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == pss_pkg::DIV_CNT_WIDTH'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rq   <= num;
      r    <= '0;
      dreg <= den;
    end else if (cnt != '0) begin
      rq <= rq_next;
      r  <= r_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pss_dp.sv =====
// Datapath: configuration registers, time accumulator, divider, multiplier, output word.
`default_nettype none

module pss_dp (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_we,
  input  wire  [pss_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  wire  [pss_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  input  wire  [pss_pkg::TIME_WIDTH-1:0]        in_delta,
  input  wire  pss_pkg::dp_cmd_t                cmd,
  output pss_pkg::dp_status_t                   status,
  input  wire                                   out_ready,
  output logic                                  out_valid,
  output logic [pss_pkg::COUNT_WIDTH-1:0]       out_count,
  output logic [pss_pkg::TIME_WIDTH-1:0]        out_length
);

  logic                              mode;
  logic [pss_pkg::TIME_WIDTH-1:0]    fixed_step;
  logic [pss_pkg::TIME_WIDTH-1:0]    min_step;
  logic [pss_pkg::TIME_WIDTH-1:0]    max_step;
  logic [pss_pkg::CAP_WIDTH-1:0]     max_substeps;

  logic [pss_pkg::ACC_WIDTH-1:0]     acc;
  logic [pss_pkg::TIME_WIDTH-1:0]    delta;
  logic [pss_pkg::CAP_WIDTH-1:0]     count;
  logic [pss_pkg::TIME_WIDTH-1:0]    length;
  logic [pss_pkg::PROD_WIDTH-1:0]    product;

  logic [pss_pkg::TIME_WIDTH-1:0]    limit;
  logic [pss_pkg::TIME_WIDTH-1:0]    thresh;
  logic [pss_pkg::ACC_WIDTH-1:0]     acc_base;
  logic [pss_pkg::ACC_WIDTH:0]       acc_sum;
  logic [pss_pkg::ACC_WIDTH-1:0]     acc_sat;
  logic [pss_pkg::TIME_WIDTH-1:0]    div_den;
  logic [pss_pkg::ACC_WIDTH-1:0]     quot;
  logic [pss_pkg::TIME_WIDTH-1:0]    rem;
  logic                              div_done;
  logic [pss_pkg::ACC_WIDTH:0]       q_ceil;
  logic [pss_pkg::CAP_WIDTH-1:0]     count_c;
  logic [pss_pkg::TIME_WIDTH-1:0]    len_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= pss_pkg::MODE_FIXED;
      fixed_step   <= pss_pkg::STEP_RESET;
      min_step     <= pss_pkg::STEP_RESET;
      max_step     <= pss_pkg::STEP_RESET;
      max_substeps <= pss_pkg::CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pss_pkg::REG_MODE:         mode         <= cfg_data[0];
        pss_pkg::REG_FIXED_STEP:   fixed_step   <= cfg_data[pss_pkg::TIME_WIDTH-1:0];
        pss_pkg::REG_MIN_STEP:     min_step     <= cfg_data[pss_pkg::TIME_WIDTH-1:0];
        pss_pkg::REG_MAX_STEP:     max_step     <= cfg_data[pss_pkg::TIME_WIDTH-1:0];
        pss_pkg::REG_MAX_SUBSTEPS: max_substeps <= cfg_data[pss_pkg::CAP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    limit    = (mode == pss_pkg::MODE_VARIABLE) ? max_step : fixed_step;
    thresh   = (mode == pss_pkg::MODE_VARIABLE) ? min_step : fixed_step;
    acc_base = (acc > {1'b0, limit}) ? '0 : acc;
    acc_sum  = {1'b0, acc_base} + (pss_pkg::ACC_WIDTH + 1)'(delta);
    // The sum overflows the accumulator exactly when its carry bit is set.
    acc_sat  = acc_sum[pss_pkg::ACC_WIDTH] ? pss_pkg::ACC_MAX
                                           : acc_sum[pss_pkg::ACC_WIDTH-1:0];
    div_den  = cmd.div_sel ? pss_pkg::TIME_WIDTH'(count) : limit;
    // Variable mode rounds the substep count up; a nonzero remainder adds one.
    q_ceil   = {1'b0, quot}
             + (pss_pkg::ACC_WIDTH + 1)'((mode == pss_pkg::MODE_VARIABLE) && (rem != '0));
    count_c  = (q_ceil > (pss_pkg::ACC_WIDTH + 1)'(max_substeps)) ? max_substeps
             : q_ceil[pss_pkg::CAP_WIDTH-1:0];
    len_c    = (quot > {1'b0, max_step}) ? max_step : quot[pss_pkg::TIME_WIDTH-1:0];
  end

  pss_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (acc),
    .den   (div_den),
    .quot  (quot),
    .rem   (rem),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.accum) begin
      acc <= acc_sat;
    end else if (cmd.update) begin
      // The simulated time never exceeds the accumulated time.
      acc <= acc - product[pss_pkg::ACC_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      delta <= in_delta;
    end
    if (cmd.no_step) begin
      count  <= '0;
      length <= '0;
    end else if (cmd.take_count) begin
      count  <= count_c;
      length <= (mode == pss_pkg::MODE_VARIABLE) ? '0 : fixed_step;
    end else if (cmd.take_length) begin
      length <= len_c;
    end
    if (cmd.mult) begin
      product <= pss_pkg::PROD_WIDTH'(count) * pss_pkg::PROD_WIDTH'(length);
    end
    if (cmd.load_out) begin
      out_count  <= pss_pkg::COUNT_WIDTH'(count);
      out_length <= (count == '0) ? '0 : length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    status.mode       = mode;
    status.reach      = acc >= {1'b0, thresh};
    status.div_done   = div_done;
    status.count_zero = (count == '0);
    status.out_free   = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

// ===== rtl/pss_ctrl.sv =====
// Controller state machine that sequences the datapath for one word.
`default_nettype none

module pss_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  output pss_pkg::dp_cmd_t     cmd,
  input  wire pss_pkg::dp_status_t status
);

  pss_pkg::state_t state;
  pss_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pss_pkg::ST_IDLE:   if (in_valid) state_next = pss_pkg::ST_ACCUM;
      pss_pkg::ST_ACCUM:  state_next = pss_pkg::ST_CHECK;
      pss_pkg::ST_CHECK:  state_next = status.reach ? pss_pkg::ST_DIV1 : pss_pkg::ST_DONE;
      pss_pkg::ST_DIV1:   if (status.div_done) state_next = pss_pkg::ST_COUNT;
      pss_pkg::ST_COUNT:  state_next = pss_pkg::ST_BRANCH;
      pss_pkg::ST_BRANCH: begin
        if (status.mode == pss_pkg::MODE_VARIABLE && !status.count_zero) begin
          state_next = pss_pkg::ST_DIV2;
        end else begin
          state_next = pss_pkg::ST_MULT;
        end
      end
      pss_pkg::ST_DIV2:   if (status.div_done) state_next = pss_pkg::ST_LENGTH;
      pss_pkg::ST_LENGTH: state_next = pss_pkg::ST_MULT;
      pss_pkg::ST_MULT:   state_next = pss_pkg::ST_UPDATE;
      pss_pkg::ST_UPDATE: state_next = pss_pkg::ST_DONE;
      pss_pkg::ST_DONE:   if (status.out_free) state_next = pss_pkg::ST_IDLE;
      default:            state_next = pss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      pss_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      pss_pkg::ST_ACCUM: cmd.accum = 1'b1;
      pss_pkg::ST_CHECK: begin
        cmd.div_start = status.reach;
        cmd.no_step   = !status.reach;
      end
      pss_pkg::ST_COUNT: cmd.take_count = 1'b1;
      pss_pkg::ST_BRANCH: begin
        cmd.div_sel   = 1'b1;
        cmd.div_start = (status.mode == pss_pkg::MODE_VARIABLE) && !status.count_zero;
      end
      pss_pkg::ST_LENGTH: cmd.take_length = 1'b1;
      pss_pkg::ST_MULT:   cmd.mult = 1'b1;
      pss_pkg::ST_UPDATE: cmd.update = 1'b1;
      pss_pkg::ST_DONE:   cmd.load_out = status.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/physics_substep_scheduler.sv =====
// Top level of the physics substep scheduler: controller, datapath and stream ports.
//
// Each input word on the s_axis channel carries one frame's elapsed time. The block
// adds it to a saturating time accumulator and returns one word on the m_axis
// channel with the number of simulation substeps to run and the length of each,
// having removed the simulated time from the accumulator. Mode 0 uses a fixed
// substep length; mode 1 splits the accumulated time evenly into substeps no
// longer than max_step. Registers are written through cfg_we/cfg_index/cfg_data
// and should only change while the block is idle.
// One word is worked on at a time. A frame that reaches the step threshold goes
// through the shared one-bit-per-cycle divider once in fixed mode and twice in
// variable mode (once if the substep count comes out zero); a frame below the
// step threshold skips the divider and goes straight to the output word.
// The output word sits in its own register, so while it waits for the receiver
// the block already accepts and computes the next word; it then holds that
// result until the output register frees up, which adds the stall to its time.
// Synchronous reset clears the accumulator, restores register defaults and
// drops m_axis_tvalid.
`default_nettype none

module physics_substep_scheduler (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  // Fields from bit 0: frame_delta.
  input  wire  [pss_pkg::IN_TDATA_WIDTH-1:0]    s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  // Fields from bit 0: substep_count, substep_length.
  output logic [pss_pkg::OUT_TDATA_WIDTH-1:0]   m_axis_tdata,
  input  wire                                   cfg_we,
  input  wire  [pss_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  wire  [pss_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

  pss_pkg::dp_cmd_t                   cmd;
  pss_pkg::dp_status_t                status;
  logic [pss_pkg::COUNT_WIDTH-1:0]    substep_count;
  logic [pss_pkg::TIME_WIDTH-1:0]     substep_length;

  pss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .status   (status)
  );

  pss_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_delta   (s_axis_tdata[pss_pkg::TIME_WIDTH-1:0]),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_count  (substep_count),
    .out_length (substep_length)
  );

  // Pack the result fields from the low bits up and fill with zeros.
  assign m_axis_tdata = pss_pkg::OUT_TDATA_WIDTH'({substep_length, substep_count});

endmodule

`default_nettype wire

// ===== rtl/pss_checker.sv =====
// Port-level assertions for the physics substep scheduler and their bind.
`default_nettype none

module pss_checker (
  input wire                                  clk,
  input wire                                  rst,
  input wire                                  s_axis_tvalid,
  input wire                                  s_axis_tready,
  input wire                                  m_axis_tvalid,
  input wire                                  m_axis_tready,
  input wire [pss_pkg::OUT_TDATA_WIDTH-1:0]   m_axis_tdata
);

  // A stalled output word stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // Only one word is in work, so input is closed right after an accept.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word accepted while one is in work");

  // A zero substep count always comes with a zero substep length.
  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[pss_pkg::COUNT_WIDTH-1:0] == '0)
    |-> (m_axis_tdata[pss_pkg::COUNT_WIDTH+pss_pkg::TIME_WIDTH-1:pss_pkg::COUNT_WIDTH]
         == '0))
    else $error("nonzero substep length with zero count");

  // Reset leaves no output word pending.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind physics_substep_scheduler pss_checker u_pss_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/substep_plan_checker.sv =====
// Scoreboard for the physics substep scheduler: predicts each output word and compares it.
`default_nettype none

module substep_plan_checker
  import pss_pkg::*;
(
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        s_axis_tvalid,
  input  wire                        s_axis_tready,
  input  wire  [IN_TDATA_WIDTH-1:0]  s_axis_tdata,
  input  wire                        m_axis_tvalid,
  input  wire                        m_axis_tready,
  input  wire  [OUT_TDATA_WIDTH-1:0] m_axis_tdata,
  input  wire                        cfg_we,
  input  wire  [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire  [CFG_DATA_WIDTH-1:0]  cfg_data,
  output int                         errors,
  output int                         pending
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] count;
    logic [TIME_WIDTH-1:0]  length;
  } substep_plan_t;

  logic                   mode_q;
  logic [TIME_WIDTH-1:0]  fixed_step_q;
  logic [TIME_WIDTH-1:0]  min_step_q;
  logic [TIME_WIDTH-1:0]  max_step_q;
  logic [CAP_WIDTH-1:0]   max_substeps_q;
  logic [ACC_WIDTH-1:0]   time_acc;
  substep_plan_t          plan_q[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Adds one frame to the accumulator and works out the substeps it releases.
  function automatic substep_plan_t schedule_frame(input logic [TIME_WIDTH-1:0] delta);
    longint unsigned limit;
    longint unsigned sum;
    longint unsigned quot;
    longint unsigned cnt;
    longint unsigned len;
    substep_plan_t   plan;
    limit = (mode_q == MODE_FIXED) ? longint'(fixed_step_q) : longint'(max_step_q);
    if (longint'(time_acc) > limit)
      time_acc = '0;
    sum = longint'(time_acc) + longint'(delta);
    if (sum > longint'(ACC_MAX))
      sum = longint'(ACC_MAX);
    cnt = 0;
    len = 0;
    if (mode_q == MODE_FIXED) begin
      if (sum >= longint'(fixed_step_q)) begin
        quot = (fixed_step_q == '0) ? '1 : sum / longint'(fixed_step_q);
        cnt  = (quot < longint'(max_substeps_q)) ? quot : longint'(max_substeps_q);
        len  = longint'(fixed_step_q);
      end
    end else if (sum >= longint'(min_step_q)) begin
      quot = (max_step_q == '0) ? '1 :
             (sum + longint'(max_step_q) - 1) / longint'(max_step_q);
      cnt  = (quot < longint'(max_substeps_q)) ? quot : longint'(max_substeps_q);
      if (cnt != 0) begin
        len = sum / cnt;
        if (len > longint'(max_step_q))
          len = longint'(max_step_q);
      end
    end
    if (cnt == 0)
      len = 0;
    sum         = sum - cnt * len;
    time_acc    = sum[ACC_WIDTH-1:0];
    plan.count  = cnt[COUNT_WIDTH-1:0];
    plan.length = len[TIME_WIDTH-1:0];
    return plan;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: %s is %0d, predicted %0d", $time, what, got, want);
    errors = errors + 1;
  endtask

  always @(posedge clk) begin
    substep_plan_t want;
    if (rst) begin
      mode_q         = MODE_FIXED;
      fixed_step_q   = STEP_RESET;
      min_step_q     = STEP_RESET;
      max_step_q     = STEP_RESET;
      max_substeps_q = CAP_RESET;
      time_acc       = '0;
      plan_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:         mode_q         = cfg_data[0];
          REG_FIXED_STEP:   fixed_step_q   = cfg_data[TIME_WIDTH-1:0];
          REG_MIN_STEP:     min_step_q     = cfg_data[TIME_WIDTH-1:0];
          REG_MAX_STEP:     max_step_q     = cfg_data[TIME_WIDTH-1:0];
          REG_MAX_SUBSTEPS: max_substeps_q = cfg_data[CAP_WIDTH-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        plan_q.push_back(schedule_frame(s_axis_tdata[TIME_WIDTH-1:0]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (plan_q.size() == 0) begin
          report_mismatch("unexpected output word, substep_count",
                          m_axis_tdata[COUNT_WIDTH-1:0], 0);
        end else begin
          want = plan_q.pop_front();
          if (m_axis_tdata[COUNT_WIDTH-1:0] !== want.count)
            report_mismatch("substep_count", m_axis_tdata[COUNT_WIDTH-1:0], want.count);
          if (m_axis_tdata[COUNT_WIDTH +: TIME_WIDTH] !== want.length)
            report_mismatch("substep_length", m_axis_tdata[COUNT_WIDTH +: TIME_WIDTH],
                            want.length);
        end
      end
    end
    pending = plan_q.size();
  end

endmodule

`default_nettype wire

// ===== tb/physics_substep_scheduler_test.sv =====
// Top of the physics substep scheduler testbench: clock, reset, stimulus and verdict.
`default_nettype none

module physics_substep_scheduler_test;

  timeunit 1ns;
  timeprecision 1ps;

  import pss_pkg::*;

  // A stretch this long without a single accepted word on either channel means
  // the block has hung. The slowest legal pause is a long sender gap plus a
  // variable-mode frame plus the receiver hold-off.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int RANDOM_PHASES  = 13;
  localparam int PHASE_WORDS    = 100;
  localparam logic [TIME_WIDTH-1:0] TIME_ONES = '1;

  logic                       clk           = 1'b0;
  logic                       rst           = 1'b1;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  // Fields from bit 0: frame_delta.
  logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata  = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  // Fields from bit 0: substep_count, substep_length.
  logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;
  logic                       cfg_we        = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index     = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data      = '0;

  int mismatches;
  int words_pending;

  // Idle controls shared between the stimulus sequence and the two drivers.
  bit gaps_on      = 1'b1;
  bit stalls_on    = 1'b1;
  int holdoff_left = 0;
  int stall_left   = 0;
  int idle_cycles  = 0;

  always #5 clk = ~clk;

  physics_substep_scheduler dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  substep_plan_checker plan_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (mismatches),
    .pending       (words_pending)
  );

  // Length of one idle stretch: mostly short, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return $urandom_range(1, 3);
    else if (r < 93)
      return $urandom_range(4, 12);
    else
      return $urandom_range(30, 150);
  endfunction

  // Frame time picked around the current step size. Most frames land within a few
  // steps so that the accumulator carries remainders from frame to frame; the rest
  // cover zero, all ones, long frames that hit the substep cap, and plain noise.
  function automatic logic [TIME_WIDTH-1:0] pick_delta(input longint unsigned scale);
    longint unsigned s;
    longint unsigned near;
    longint unsigned far;
    longint unsigned v;
    s    = (scale == 0) ? 1 : scale;
    near = (s * 3 > longint'(TIME_ONES)) ? longint'(TIME_ONES) : s * 3;
    far  = (s * 300 > longint'(TIME_ONES)) ? longint'(TIME_ONES) : s * 300;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $urandom_range(32'(near), 0);
      5:             v = $urandom_range(32'(far), 0);
      6:             v = s - 1 + $urandom_range(0, 2);
      7:             v = 0;
      8:             v = longint'(TIME_ONES);
      default:       v = $urandom();
    endcase
    if (v > longint'(TIME_ONES))
      v = longint'(TIME_ONES);
    return v[TIME_WIDTH-1:0];
  endfunction

  // Step register value: usually a realistic frame-rate step, sometimes the
  // smallest or largest, rarely zero which makes the divider saturate.
  function automatic logic [TIME_WIDTH-1:0] pick_step();
    case ($urandom_range(0, 19))
      0:       return TIME_WIDTH'(1);
      1, 2:    return TIME_WIDTH'($urandom_range(2, 16));
      3:       return TIME_ONES;
      4:       return '0;
      5, 6:    return TIME_WIDTH'($urandom_range(32'(TIME_ONES), 1));
      default: return TIME_WIDTH'($urandom_range(500, 5000));
    endcase
  endfunction

  function automatic logic [CAP_WIDTH-1:0] pick_cap();
    case ($urandom_range(0, 9))
      0:       return CAP_WIDTH'(1);
      1:       return '1;
      2:       return '0;
      3, 4, 5: return CAP_RESET;
      default: return CAP_WIDTH'($urandom_range(1, 255));
    endcase
  endfunction

  // Offers one word and returns at the rising edge that accepts it. Valid stays
  // high into the next word unless a gap is drawn, so there is only ever one
  // assignment to it per falling edge.
  task automatic send_frame(input logic [TIME_WIDTH-1:0] delta);
    int gap;
    gap = (gaps_on && $urandom_range(0, 99) < 40) ? idle_length() : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_WIDTH'(delta);
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stops offering and waits until every predicted word has come back, so the
  // block is idle and the registers may be rewritten.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index,
                           input logic [CFG_DATA_WIDTH-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
  endtask

  task automatic load_settings(input logic mode, input logic [TIME_WIDTH-1:0] fixed_step,
                               input logic [TIME_WIDTH-1:0] min_step,
                               input logic [TIME_WIDTH-1:0] max_step,
                               input logic [CAP_WIDTH-1:0] max_substeps);
    write_reg(REG_MODE, CFG_DATA_WIDTH'(mode));
    write_reg(REG_FIXED_STEP, CFG_DATA_WIDTH'(fixed_step));
    write_reg(REG_MIN_STEP, CFG_DATA_WIDTH'(min_step));
    write_reg(REG_MAX_STEP, CFG_DATA_WIDTH'(max_step));
    write_reg(REG_MAX_SUBSTEPS, CFG_DATA_WIDTH'(max_substeps));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: a long hold-off requested by the sequence wins, then any stall in
  // progress, otherwise a fresh stall may start or the word is taken.
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      m_axis_tready <= 1'b0;
      holdoff_left = holdoff_left - 1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 99) < 30) begin
      m_axis_tready <= 1'b0;
      stall_left = idle_length() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: any accepted word on either channel counts as progress.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic                  mode_pick;
    logic [TIME_WIDTH-1:0] fixed_pick;
    logic [TIME_WIDTH-1:0] min_pick;
    logic [TIME_WIDTH-1:0] max_pick;
    logic [CAP_WIDTH-1:0]  cap_pick;
    longint unsigned       scale;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Register defaults: fixed mode with a sixtieth-of-a-second step. Covers an empty
    // frame, a frame exactly one step long, one just short of it (only accumulates,
    // length reads zero), a top-up, two frames that hit the cap, a two-step frame.
    send_frame('0);
    send_frame(TIME_WIDTH'(1092));
    send_frame(TIME_WIDTH'(1091));
    send_frame(TIME_WIDTH'(1));
    send_frame(TIME_ONES);
    send_frame(TIME_WIDTH'(24'h800000));
    send_frame(TIME_WIDTH'(2184));
    drain();

    // Zero fixed step: the divider gives all ones, so the cap wins and the
    // length is zero without draining the accumulator.
    load_settings(MODE_FIXED, '0, STEP_RESET, STEP_RESET, CAP_RESET);
    send_frame(TIME_WIDTH'(5));
    send_frame(TIME_ONES);
    drain();

    // Largest step with a cap of one: the accumulator climbs toward its top bit.
    load_settings(MODE_FIXED, TIME_ONES, STEP_RESET, STEP_RESET, CAP_WIDTH'(1));
    send_frame(TIME_ONES);
    send_frame(TIME_ONES - 1);
    send_frame(TIME_ONES);
    drain();

    // Zero cap never steps; then the smallest step with the largest cap.
    load_settings(MODE_FIXED, TIME_WIDTH'(3), STEP_RESET, STEP_RESET, '0);
    send_frame(TIME_WIDTH'(10));
    drain();
    load_settings(MODE_FIXED, TIME_WIDTH'(1), STEP_RESET, STEP_RESET, '1);
    send_frame(TIME_ONES);
    drain();

    // Variable mode with no minimum: an empty accumulator gives a zero ceiling.
    load_settings(MODE_VARIABLE, STEP_RESET, '0, STEP_RESET, CAP_RESET);
    send_frame('0);
    send_frame(TIME_WIDTH'(5000));
    send_frame(TIME_ONES);
    drain();

    // Zero max step in variable mode: count takes the cap and length is zero.
    load_settings(MODE_VARIABLE, STEP_RESET, STEP_RESET, '0, CAP_RESET);
    send_frame(TIME_WIDTH'(2000));
    drain();

    // Largest minimum and max step with the largest cap, then a zero cap.
    load_settings(MODE_VARIABLE, STEP_RESET, TIME_ONES, TIME_ONES, '1);
    send_frame(TIME_ONES - 1);
    send_frame(TIME_ONES);
    drain();
    load_settings(MODE_VARIABLE, STEP_RESET, TIME_WIDTH'(100), TIME_WIDTH'(1), '0);
    send_frame(TIME_WIDTH'(200));
    drain();

    // Random phases, each with its own register settings. The first two pin the
    // extremes; idling is switched off on one side or the other in some phases,
    // and one phase holds the receiver off while the sender keeps offering so the
    // output register and the datapath both fill and the input stalls.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      mode_pick  = ($urandom_range(0, 1) == 1) ? MODE_VARIABLE : MODE_FIXED;
      fixed_pick = pick_step();
      max_pick   = pick_step();
      case ($urandom_range(0, 5))
        0:       min_pick = '0;
        1:       min_pick = TIME_ONES;
        default: min_pick = TIME_WIDTH'($urandom_range(32'(max_pick), 0));
      endcase
      cap_pick = pick_cap();
      if (p == 0) begin
        mode_pick  = MODE_FIXED;
        fixed_pick = TIME_WIDTH'(1);
        cap_pick   = '1;
      end else if (p == 1) begin
        mode_pick = MODE_VARIABLE;
        min_pick  = '0;
        max_pick  = TIME_ONES;
        cap_pick  = CAP_WIDTH'(1);
      end
      load_settings(mode_pick, fixed_pick, min_pick, max_pick, cap_pick);
      scale     = (mode_pick == MODE_FIXED) ? longint'(fixed_pick) : longint'(max_pick);
      gaps_on   = (p % 4 != 1);
      stalls_on = (p % 4 != 2);
      if (p == 3) begin
        gaps_on = 1'b0;
        @(posedge clk);
        holdoff_left = HOLDOFF_CYCLES;
      end
      repeat (PHASE_WORDS) send_frame(pick_delta(scale));
      drain();
    end

    // Everything has come back; give the block a variable-mode latency to show
    // any stray word before the verdict.
    repeat (80) @(negedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/pss_pkg.sv
rtl/pss_div.sv
rtl/pss_dp.sv
rtl/pss_ctrl.sv
rtl/physics_substep_scheduler.sv
rtl/pss_checker.sv
tb/substep_plan_checker.sv
tb/physics_substep_scheduler_test.sv
